FILE: hdl/tcl_pkg.sv
// ----------------------------------------------------------------------------
// tcl_pkg: shared types for the tile cache LRU table
// Entry layout, sequencer states and scan unit control.
// ----------------------------------------------------------------------------
`default_nettype none

package tcl_pkg;

	localparam int ZOOM_W = 5;
	localparam int COORD_W = 20;
	localparam int WORD_W = 32;
	localparam int SLOT_W = 6;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	// one stored tile entry (valid bit kept apart, in flops)
	typedef struct packed {
		logic               empty;
		logic [ZOOM_W-1:0]  zoom;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [WORD_W-1:0]  buffer;
		logic [WORD_W-1:0]  last_use;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clr;  // restart accumulators for a new item
		logic vld;  // read data of one entry present this cycle
	} scan_ctl_t;

endpackage : tcl_pkg

`default_nettype wire

FILE: hdl/tcl_store.sv
// ----------------------------------------------------------------------------
// tcl_store: entry memory with per-entry valid flops
// One registered read port and one write port; unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_store
	import tcl_pkg::*;
#(
	parameter int ENTRIES = 48
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
	output logic                            rd_vld,
	output entry_t                          rd_ent,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  wire entry_t                     wr_ent
);

	entry_t             mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	entry_t             rd_q;
	logic               rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_ent;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	// never-written entries hold junk in the array; mask to reset value
	assign rd_vld = rd_vld_q;
	assign rd_ent = rd_vld_q ? rd_q : '0;

endmodule : tcl_store

`default_nettype wire

FILE: hdl/tcl_scan.sv
// ----------------------------------------------------------------------------
// tcl_scan: shared tag compare and oldest-time select unit
// Looks at one entry per cycle; keeps first match and eviction candidate.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_scan
	import tcl_pkg::*;
#(
	parameter int ENTRIES = 48
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire scan_ctl_t                  ctl,
	input  wire logic [$clog2(ENTRIES)-1:0] idx,
	input  wire logic                       ent_vld,
	input  wire entry_t                     ent,
	input  wire logic [ZOOM_W-1:0]          zoom,
	input  wire logic [COORD_W-1:0]         col,
	input  wire logic [COORD_W-1:0]         row,
	output logic                            found,
	output logic [$clog2(ENTRIES)-1:0]      match_idx,
	output entry_t                          match_ent,
	output logic [$clog2(ENTRIES)-1:0]      vict_idx,
	output logic [WORD_W-1:0]               vict_buf
);

	localparam int IW = $clog2(ENTRIES);

	logic              found_q;
	logic              inv_q;
	logic [IW-1:0]     midx_q;
	entry_t            ment_q;
	logic [IW-1:0]     vidx_q;
	logic [WORD_W-1:0] vbuf_q;
	logic [WORD_W-1:0] best_q;
	logic              tag_eq;
	logic              older;

	assign tag_eq = ent_vld && (ent.zoom == zoom) && (ent.col == col) && (ent.row == row);
	// entry 0 always seeds the candidate, so an all-maximum table picks it
	assign older  = (idx == '0) || (ent.last_use < best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			inv_q   <= 1'b0;
		end else if (ctl.clr) begin
			found_q <= 1'b0;
			inv_q   <= 1'b0;
		end else if (ctl.vld) begin
			if (tag_eq && !found_q) begin
				found_q <= 1'b1;
			end
			if (!ent_vld && !inv_q) begin
				inv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			best_q <= '1;
			vidx_q <= '0;
			vbuf_q <= '0;
		end else if (ctl.vld) begin
			if (tag_eq && !found_q) begin
				midx_q <= idx;
				ment_q <= ent;
			end
			if (!inv_q) begin
				if (!ent_vld) begin
					vidx_q <= idx;
					vbuf_q <= '0;
				end else if (older) begin
					vidx_q <= idx;
					vbuf_q <= ent.buffer;
					best_q <= ent.last_use;
				end
			end
		end
	end

	assign found     = found_q;
	assign match_idx = midx_q;
	assign match_ent = ment_q;
	assign vict_idx  = vidx_q;
	assign vict_buf  = vbuf_q;

endmodule : tcl_scan

`default_nettype wire

FILE: hdl/tile_cache_lru_table.sv
// ----------------------------------------------------------------------------
// tile_cache_lru_table: fully associative LRU table of map tiles
// Lookup and insert of tiles keyed by zoom, column and row.
// ----------------------------------------------------------------------------
// Usage:
//  - Request items enter on the s_ channel. s_tuser = {is_empty, op}; op 0 is
//    a lookup, op 1 an insert. s_tdata carries zoom, col, row, now, buffer_in.
//  - One result item per request leaves on the m_ channel: m_tuser holds the
//    hit, fetch_request and release_valid marks, m_tdata buffer_out,
//    release_handle and slot_used.
//  - Each item walks all ENTRIES entries through one compare/select unit,
//    one entry per cycle from the entry memory's single read port. The result
//    is loaded into the output register in the final step, after the last entry
//    has been compared; s_tready is high only while the sequencer is idle, so a
//    new item is not taken until the last one has left its final step.
//  - The result sits in an output register. If the receiver stalls, the next
//    item is still taken and scanned, and waits in its final step until the
//    output register is free; the table is updated in that same step.
//  - Reset clears the per-entry valid flops at once, so the table is empty
//    and ready for an item as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_cache_lru_table
	import tcl_pkg::*;
#(
	parameter int ENTRIES = 48
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [111:0] s_tdata,   // zoom, col, row, now, buffer_in, 3'b0
	input  wire logic [1:0]   s_tuser,   // op, is_empty
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [71:0]       m_tdata,   // buffer_out, release_handle, slot_used, 2'b0
	output logic [2:0]        m_tuser    // hit, fetch_request, release_valid
);

	localparam int IW = $clog2(ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	// request register
	op_t                req_op_q;
	logic               req_empty_q;
	logic [ZOOM_W-1:0]  req_zoom_q;
	logic [COORD_W-1:0] req_col_q;
	logic [COORD_W-1:0] req_row_q;
	logic [WORD_W-1:0]  req_now_q;
	logic [WORD_W-1:0]  req_buf_q;

	state_t        state_q, state_d;
	logic [IW-1:0] cnt_q;
	logic          scan_s1;
	logic [IW-1:0] idx_s1;
	logic          accept;
	logic          out_free;
	logic          fin_go;

	// store / scan wiring
	logic          rd_en;
	logic          rd_vld;
	entry_t        rd_ent;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_ent;
	scan_ctl_t     sctl;
	logic          found;
	logic [IW-1:0] match_idx;
	entry_t        match_ent;
	logic [IW-1:0] vict_idx;
	logic [WORD_W-1:0] vict_buf;

	// result
	logic              res_hit, res_fetch, res_rel;
	logic [WORD_W-1:0] res_buf, res_rel_h;
	logic [SLOT_W-1:0] res_slot;
	logic              out_vld_q;
	logic              hit_q, fetch_q, rel_q;
	logic [WORD_W-1:0] buf_out_q, rel_h_q;
	logic [SLOT_W-1:0] slot_q;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_SCAN;
			ST_SCAN:   if (cnt_q == LAST_IDX) state_d = ST_LAST;
			ST_LAST:   state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		fin_go   = 1'b0;
		case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_SCAN:   rd_en = 1'b1;
			ST_LAST:   ;
			ST_FINISH: fin_go = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			scan_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_s1 <= rd_en;
			if (accept) begin
				cnt_q <= '0;
			end else if (rd_en && cnt_q != LAST_IDX) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			req_op_q    <= op_t'(s_tuser[0]);
			req_empty_q <= s_tuser[1];
			req_zoom_q  <= s_tdata[4:0];
			req_col_q   <= s_tdata[24:5];
			req_row_q   <= s_tdata[44:25];
			req_now_q   <= s_tdata[76:45];
			req_buf_q   <= s_tdata[108:77];
		end
	end

	assign sctl = '{clr: accept, vld: scan_s1};

	tcl_store #(
		.ENTRIES(ENTRIES)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(cnt_q),
		.rd_vld (rd_vld),
		.rd_ent (rd_ent),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_ent (wr_ent)
	);

	tcl_scan #(
		.ENTRIES(ENTRIES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sctl),
		.idx      (idx_s1),
		.ent_vld  (rd_vld),
		.ent      (rd_ent),
		.zoom     (req_zoom_q),
		.col      (req_col_q),
		.row      (req_row_q),
		.found    (found),
		.match_idx(match_idx),
		.match_ent(match_ent),
		.vict_idx (vict_idx),
		.vict_buf (vict_buf)
	);

	// result of the finished scan
	always_comb begin
		res_hit   = found;
		res_buf   = '0;
		res_fetch = 1'b0;
		res_rel   = 1'b0;
		res_rel_h = '0;
		res_slot  = '0;
		if (found) begin
			res_slot = SLOT_W'(match_idx);
			if (req_op_q == OP_LOOKUP) begin
				if (!match_ent.empty) res_buf = match_ent.buffer;
			end else if (req_buf_q != '0) begin
				// duplicate insert: incoming handle goes back to the host
				res_rel   = 1'b1;
				res_rel_h = req_buf_q;
			end
		end else if (req_op_q == OP_LOOKUP) begin
			res_fetch = 1'b1;
		end else begin
			res_slot = SLOT_W'(vict_idx);
			if (vict_buf != '0) begin
				res_rel   = 1'b1;
				res_rel_h = vict_buf;
			end
		end
	end

	// table update: refresh the hit entry's time, or fill the victim
	always_comb begin
		wr_en   = fin_go && (found || req_op_q == OP_INSERT);
		wr_addr = found ? match_idx : vict_idx;
		if (found) begin
			wr_ent          = match_ent;
			wr_ent.last_use = req_now_q;
		end else begin
			wr_ent.empty    = req_empty_q;
			wr_ent.zoom     = req_zoom_q;
			wr_ent.col      = req_col_q;
			wr_ent.row      = req_row_q;
			wr_ent.buffer   = req_buf_q;
			wr_ent.last_use = req_now_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fin_go) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			hit_q     <= res_hit;
			fetch_q   <= res_fetch;
			rel_q     <= res_rel;
			buf_out_q <= res_buf;
			rel_h_q   <= res_rel_h;
			slot_q    <= res_slot;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, slot_q, rel_h_q, buf_out_q};
	assign m_tuser  = {rel_q, fetch_q, hit_q};

	// a completed scan always lands in the output register
	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> m_tvalid)
		else $error("finished item not presented");

	// a lookup miss cannot also report a hit
	a_fetch_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && fetch_q) |-> !hit_q)
		else $error("fetch request together with hit");

	// a release always carries a real handle
	a_rel_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && rel_q) |-> (rel_h_q != '0))
		else $error("release of null handle");

	// the table is only written in the final step of an item
	a_wr_finish: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_FINISH))
		else $error("table written outside final step");

endmodule : tile_cache_lru_table

`default_nettype wire
